// ===== rtl/lea128_block_cipher_unit_assert.svh =====
// Assertion macros for the LEA-128 block cipher unit.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef LEA128_BLOCK_CIPHER_UNIT_ASSERT_SVH
`define LEA128_BLOCK_CIPHER_UNIT_ASSERT_SVH

// same-cycle implication under reset
`define LEA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lea128 check failed");

// next-cycle implication under reset
`define LEA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lea128 check failed");

`endif

// ===== rtl/lea128_pkg.sv =====
// Shared types, constants and helpers for the LEA-128 block cipher unit.
// No dependencies.
package lea128_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXPAND,
		ST_LOAD,
		ST_RUN,
		ST_DONE
	} state_t;

	localparam logic REG_KEY_LOW  = 1'b0;
	localparam logic REG_KEY_HIGH = 1'b1;

	localparam logic OP_ENCRYPT = 1'b0;

	localparam logic [3:0][31:0] DELTA = {
		32'h78df30ec, 32'h79e27c8a, 32'h44626b02, 32'hc3efe9db
	};

	function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
		logic [63:0] d;
		d = {x, x} << n;
		return d[63:32];
	endfunction

endpackage

// ===== rtl/lea128_block_cipher_unit.sv =====
// LEA-128 ECB cipher top level; depends on lea128_pkg, lea128_ram, lea128_round
// and the assertion macro header. An accepted block has its round keys expanded
// (only after reset or a key write), the first round key loaded, its rounds run
// one per cycle through the round-key RAM read port, and its result registered;
// no new block is taken before that. Reset clears the keys to zero and marks the
// round-key RAM stale; it is refilled before the next block.
`include "lea128_block_cipher_unit_assert.svh"

module lea128_block_cipher_unit #(
	parameter int ROUNDS = 24
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [0:0]   cfg_index,
	input  logic [63:0]  cfg_wdata,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,   // block_low [63:0], block_high [127:64]
	input  logic [0:0]   s_axis_tuser,   // opcode [0]
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata    // out_low [63:0], out_high [127:64]
);
	import lea128_pkg::*;

	localparam int AW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
	localparam logic [AW-1:0] LAST = AW'(ROUNDS - 1);

	state_t        state_q, nxt_state;
	logic [63:0]   key_low_q, key_high_q;
	logic          keys_ready_q;
	logic [3:0][31:0] t_q, t_nxt;
	logic [AW-1:0] exp_cnt_q, ridx_q, nidx, rem_q;
	logic          dec_q;
	logic [127:0]  x_q, x_round;
	logic          m_valid_q;
	logic [127:0]  m_data_q;

	logic          accept, out_free, last_exp;
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_raddr;
	logic [127:0]  ram_rdata;
	logic [4:0]    rnd5;
	logic [31:0]   dlt;

	assign accept   = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_valid_q || m_axis_tready;
	assign last_exp = (exp_cnt_q == LAST);
	assign nidx     = dec_q ? ridx_q - AW'(1) : ridx_q + AW'(1);

	// key schedule step
	always_comb begin
		rnd5 = 5'(exp_cnt_q);
		dlt  = DELTA[rnd5[1:0]];
		t_nxt[0] = rotl(t_q[0] + rotl(dlt, rnd5), 5'd1);
		t_nxt[1] = rotl(t_q[1] + rotl(dlt, rnd5 + 5'd1), 5'd3);
		t_nxt[2] = rotl(t_q[2] + rotl(dlt, rnd5 + 5'd2), 5'd6);
		t_nxt[3] = rotl(t_q[3] + rotl(dlt, rnd5 + 5'd3), 5'd11);
	end

	always_comb begin
		nxt_state = state_q;
		unique case (state_q)
			ST_IDLE:   if (accept) nxt_state = keys_ready_q ? ST_LOAD : ST_EXPAND;
			ST_EXPAND: if (last_exp) nxt_state = ST_LOAD;
			ST_LOAD:   nxt_state = ST_RUN;
			ST_RUN:    if (rem_q == '0) nxt_state = ST_DONE;
			ST_DONE:   if (out_free) nxt_state = ST_IDLE;
			default:   nxt_state = ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		ram_we        = 1'b0;
		ram_re        = 1'b0;
		ram_raddr     = ridx_q;
		unique case (state_q)
			ST_IDLE:   s_axis_tready = 1'b1;
			ST_EXPAND: ram_we = 1'b1;
			ST_LOAD:   ram_re = 1'b1;
			ST_RUN: begin
				ram_re    = (rem_q != '0);
				ram_raddr = nidx;
			end
			ST_DONE:   ;
			default:   ;
		endcase
	end

	lea128_ram #(
		.WIDTH(128),
		.DEPTH(ROUNDS)
	) u_rk_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(exp_cnt_q),
		.wdata(t_nxt),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	lea128_round u_round (
		.dec  (dec_q),
		.x_in (x_q),
		.rk   (ram_rdata),
		.x_out(x_round)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			key_low_q    <= '0;
			key_high_q   <= '0;
			keys_ready_q <= 1'b0;
			m_valid_q    <= 1'b0;
		end else begin
			state_q <= nxt_state;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_KEY_LOW:  key_low_q  <= cfg_wdata;
					REG_KEY_HIGH: key_high_q <= cfg_wdata;
					default:      ;
				endcase
				keys_ready_q <= 1'b0;
			end else if (state_q == ST_EXPAND && last_exp) begin
				keys_ready_q <= 1'b1;
			end
			if (state_q == ST_DONE && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q       <= s_axis_tdata;
			dec_q     <= (s_axis_tuser[0] != OP_ENCRYPT);
			ridx_q    <= (s_axis_tuser[0] != OP_ENCRYPT) ? LAST : '0;
			exp_cnt_q <= '0;
			t_q       <= {key_high_q, key_low_q};
		end
		if (state_q == ST_EXPAND) begin
			t_q       <= t_nxt;
			exp_cnt_q <= exp_cnt_q + AW'(1);
		end
		if (state_q == ST_LOAD) begin
			rem_q <= LAST;
		end
		if (state_q == ST_RUN) begin
			x_q    <= x_round;
			rem_q  <= rem_q - AW'(1);
			ridx_q <= nidx;
		end
		if (state_q == ST_DONE && out_free) begin
			m_data_q <= x_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	`LEA_ASSERT_NOW(a_keys_before_run, clk, arst_n, state_q == ST_RUN, keys_ready_q)
	`LEA_ASSERT_NEXT(a_accept_starts, clk, arst_n, accept,
		state_q == ST_LOAD || state_q == ST_EXPAND)
	`LEA_ASSERT_NEXT(a_done_emits, clk, arst_n, state_q == ST_DONE && out_free,
		m_axis_tvalid && state_q == ST_IDLE)
	`LEA_ASSERT_NEXT(a_cfg_stales_keys, clk, arst_n, cfg_we, !keys_ready_q)

endmodule

// ===== rtl/lea128_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lea128_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 24
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/lea128_round.sv =====
// One LEA-128 round, encryption or decryption, on a 128-bit state.
// Depends on lea128_pkg.
module lea128_round (
	input  logic         dec,
	input  logic [127:0] x_in,
	input  logic [127:0] rk,
	output logic [127:0] x_out
);
	import lea128_pkg::*;

	logic [31:0] x0, x1, x2, x3;
	logic [31:0] k0, k1, k2, k3;
	logic [31:0] e0, e1, e2;
	logic [31:0] d1, d2, d3;

	assign {x3, x2, x1, x0} = x_in;
	assign {k3, k2, k1, k0} = rk;

	always_comb begin
		e0 = rotl((x0 ^ k0) + (x1 ^ k1), 5'd9);
		e1 = rotl((x1 ^ k2) + (x2 ^ k1), 5'd27);
		e2 = rotl((x2 ^ k3) + (x3 ^ k1), 5'd29);
		d1 = (rotl(x0, 5'd23) - (x3 ^ k0)) ^ k1;
		d2 = (rotl(x1, 5'd5) - (d1 ^ k2)) ^ k1;
		d3 = (rotl(x2, 5'd3) - (d2 ^ k3)) ^ k1;
	end

	assign x_out = dec ? {d3, d2, d1, x3} : {x0, e2, e1, e0};

endmodule

// ===== test/lea128_block_cipher_unit_test.sv =====
// Self-checking testbench for lea128_block_cipher_unit: ECB encrypt and decrypt of
// blocks under several keys. Depends on lea128_pkg and the unit's RTL; predicts each
// block with its own LEA-128 model in a scoreboard class.
module lea128_block_cipher_unit_test;
	import lea128_pkg::*;

	localparam int ROUNDS = 24;
	localparam logic OP_DECRYPT = 1'b1;
	localparam logic [127:0] KEY_DELTA = {
		32'h78df30ec, 32'h79e27c8a, 32'h44626b02, 32'hc3efe9db
	};

	typedef struct packed {
		logic [63:0] hi;
		logic [63:0] lo;
	} block_t;

	function automatic logic [31:0] rol32(logic [31:0] x, int unsigned n);
		int unsigned s;
		s = n % 32;
		if (s == 0) begin
			return x;
		end
		return (x << s) | (x >> (32 - s));
	endfunction

	function automatic logic [31:0] ror32(logic [31:0] x, int unsigned n);
		return rol32(x, (32 - n % 32) % 32);
	endfunction

	class lea_scoreboard;
		logic [63:0] key_lo;
		logic [63:0] key_hi;
		bit keys_ready;
		logic [31:0] rk [ROUNDS][4];
		block_t expected_blocks [$];
		int errors;

		function new();
			key_lo = '0;
			key_hi = '0;
			keys_ready = 0;
			errors = 0;
		endfunction

		function void set_key(logic idx, logic [63:0] v);
			if (idx == REG_KEY_LOW) begin
				key_lo = v;
			end else begin
				key_hi = v;
			end
			keys_ready = 0;
		endfunction

		function void expand_round_keys();
			logic [31:0] t0, t1, t2, t3, d;
			t0 = key_lo[31:0];
			t1 = key_lo[63:32];
			t2 = key_hi[31:0];
			t3 = key_hi[63:32];
			for (int unsigned r = 0; r < ROUNDS; r++) begin
				d = KEY_DELTA[32 * (r % 4) +: 32];
				t0 = rol32(t0 + rol32(d, r), 1);
				t1 = rol32(t1 + rol32(d, r + 1), 3);
				t2 = rol32(t2 + rol32(d, r + 2), 6);
				t3 = rol32(t3 + rol32(d, r + 3), 11);
				rk[r][0] = t0;
				rk[r][1] = t1;
				rk[r][2] = t2;
				rk[r][3] = t3;
			end
			keys_ready = 1;
		endfunction

		function block_t cipher_block(logic op, block_t b);
			logic [31:0] x0, x1, x2, x3, y0, y1, y2, y3;
			block_t res;
			x0 = b.lo[31:0];
			x1 = b.lo[63:32];
			x2 = b.hi[31:0];
			x3 = b.hi[63:32];
			if (!keys_ready) begin
				expand_round_keys();
			end
			if (op == OP_ENCRYPT) begin
				for (int r = 0; r < ROUNDS; r++) begin
					y0 = x0;
					x0 = rol32((x0 ^ rk[r][0]) + (x1 ^ rk[r][1]), 9);
					x1 = ror32((x1 ^ rk[r][2]) + (x2 ^ rk[r][1]), 5);
					x2 = ror32((x2 ^ rk[r][3]) + (x3 ^ rk[r][1]), 3);
					x3 = y0;
				end
			end else begin
				for (int r = ROUNDS - 1; r >= 0; r--) begin
					y0 = x0;
					y1 = x1;
					y2 = x2;
					y3 = x3;
					x0 = y3;
					x1 = (ror32(y0, 9) - (x0 ^ rk[r][0])) ^ rk[r][1];
					x2 = (rol32(y1, 5) - (x1 ^ rk[r][2])) ^ rk[r][1];
					x3 = (rol32(y2, 3) - (x2 ^ rk[r][3])) ^ rk[r][1];
				end
			end
			res.lo = {x1, x0};
			res.hi = {x3, x2};
			return res;
		endfunction

		function block_t note_block(logic op, block_t b);
			block_t res;
			res = cipher_block(op, b);
			expected_blocks.push_back(res);
			return res;
		endfunction

		task report(string msg);
			$display("MISMATCH: %s", msg);
			errors++;
		endtask

		task check_result(block_t got);
			block_t want;
			if (expected_blocks.size() == 0) begin
				report($sformatf("unexpected result %h", got));
				return;
			end
			want = expected_blocks.pop_front();
			if (got.lo !== want.lo) begin
				report($sformatf("out_low got %h expected %h", got.lo, want.lo));
			end
			if (got.hi !== want.hi) begin
				report($sformatf("out_high got %h expected %h", got.hi, want.hi));
			end
		endtask

		function int pending();
			return expected_blocks.size();
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [0:0]   cfg_index;
	logic [63:0]  cfg_wdata;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata;   // block_low [63:0], block_high [127:64]
	logic [0:0]   s_axis_tuser;   // opcode [0]
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [127:0] m_axis_tdata;   // out_low [63:0], out_high [127:64]

	lea128_block_cipher_unit #(.ROUNDS(ROUNDS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	lea_scoreboard board = new();
	int send_idle_pct;
	int recv_stall_pct;
	block_t last_ct;
	bit have_ct;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("Some tests failed");
		$finish;
	end

	always @(posedge clk) begin
		m_axis_tready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			board.check_result(m_axis_tdata);
		end
	end

	function automatic logic [63:0] rand64();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task send_block(logic op, block_t b);
		block_t res;
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= b;
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		res = board.note_block(op, b);
		if (op == OP_ENCRYPT) begin
			last_ct = res;
			have_ct = 1;
		end
	endtask

	// hold the sender off until every block in flight has come back
	task drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0) begin
			@(posedge clk);
		end
	endtask

	task load_key(bit do_lo, bit do_hi, logic [63:0] lo, logic [63:0] hi);
		if (do_lo) begin
			cfg_we <= 1'b1;
			cfg_index <= REG_KEY_LOW;
			cfg_wdata <= lo;
			@(posedge clk);
			board.set_key(REG_KEY_LOW, lo);
		end
		if (do_hi) begin
			cfg_we <= 1'b1;
			cfg_index <= REG_KEY_HIGH;
			cfg_wdata <= hi;
			@(posedge clk);
			board.set_key(REG_KEY_HIGH, hi);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task run_phase(int sidle, int rstall);
		send_idle_pct = sidle;
		recv_stall_pct = rstall;
		repeat (5) begin
			drain();
			case ($urandom_range(2))
				0: load_key(1, 1, rand64(), rand64());
				1: load_key(1, 0, rand64(), '0);
				default: load_key(0, 1, '0, rand64());
			endcase
			repeat (25) begin
				// some encrypt/decrypt round trips, mostly random blocks
				if (have_ct && $urandom_range(99) < 40) begin
					send_block(OP_DECRYPT, last_ct);
					have_ct = 0;
				end else begin
					send_block($urandom_range(1) ? OP_DECRYPT : OP_ENCRYPT,
						block_t'{hi: rand64(), lo: rand64()});
				end
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_KEY_LOW;
		cfg_wdata <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= OP_ENCRYPT;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		have_ct = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all-zero key straight after reset
		send_block(OP_ENCRYPT, '0);
		send_block(OP_ENCRYPT, '1);
		send_block(OP_DECRYPT, '0);
		send_block(OP_DECRYPT, '1);

		drain();
		load_key(1, 1, 64'h78695a4b3c2d1e0f, 64'hf0e1d2c3b4a59687);
		send_block(OP_ENCRYPT, block_t'{hi: 64'h1f1e1d1c1b1a1918, lo: 64'h1716151413121110});
		send_block(OP_DECRYPT, block_t'{hi: 64'h04648bfd5532c7a7, lo: 64'h28c6c6189fc84e35});
		send_block(OP_ENCRYPT, block_t'{hi: 64'haaaaaaaaaaaaaaaa, lo: 64'h5555555555555555});

		drain();
		load_key(1, 1, '1, '1);
		send_block(OP_ENCRYPT, '0);
		send_block(OP_DECRYPT, '1);
		send_block(OP_ENCRYPT, block_t'{hi: 64'h5555555555555555, lo: 64'haaaaaaaaaaaaaaaa});

		// single-register writes must also force a new expansion
		drain();
		load_key(0, 1, '0, {$urandom, $urandom});
		send_block(OP_ENCRYPT, block_t'{hi: rand64(), lo: rand64()});
		send_block(OP_DECRYPT, last_ct);

		drain();
		load_key(1, 0, '0, '0);
		send_block(OP_ENCRYPT, block_t'{hi: 64'h8000000000000001, lo: 64'h0000000180000000});
		send_block(OP_DECRYPT, last_ct);

		run_phase(0, 0);
		run_phase(73, 0);
		run_phase(0, 73);
		run_phase(6, 6);

		drain();
		repeat (60) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/lea128_pkg.sv
rtl/lea128_ram.sv
rtl/lea128_round.sv
rtl/lea128_block_cipher_unit.sv
test/lea128_block_cipher_unit_test.sv
